FILE: rtl/core/tilt_gesture_classifier_assert.svh
// Assertion macros for the tilt gesture classifier RTL.
// Depends on nothing; included by the top-level module, which carries the assertions.
`ifndef TILT_GESTURE_CLASSIFIER_ASSERT_SVH
`define TILT_GESTURE_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled while the active-low reset is asserted.
`define TGC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tilt gesture classifier assertion failed");

// Next-cycle implication, disabled while the active-low reset is asserted.
`define TGC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tilt gesture classifier assertion failed");

`endif

FILE: rtl/core/tgc_pkg.sv
// Shared types, constants and register indexes of the tilt gesture classifier.
// Depends on nothing; every RTL module uses it by scoped names.
package tgc_pkg;

    localparam int WINDOW    = 32;
    localparam int WIN_SHIFT = $clog2(WINDOW);
    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = SAMPLE_W + WIN_SHIFT;

    localparam logic [2:0] CFG_HYSTERESIS   = 3'd0;
    localparam logic [2:0] CFG_Z_ON_LEVEL   = 3'd1;
    localparam logic [2:0] CFG_TILT_RANGE   = 3'd2;
    localparam logic [2:0] CFG_POSITIVE_REF = 3'd3;
    localparam logic [2:0] CFG_NEGATIVE_REF = 3'd4;

    localparam logic [14:0] RST_HYSTERESIS   = 15'd4000;
    localparam logic [14:0] RST_Z_ON_LEVEL   = 15'd6000;
    localparam logic [14:0] RST_TILT_RANGE   = 15'd4000;
    localparam logic [14:0] RST_POSITIVE_REF = 15'd16384;
    localparam logic [15:0] RST_NEGATIVE_REF = 16'hC000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] z;
    } sample_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } sum_t;

    typedef struct packed {
        logic [14:0]        hysteresis;
        logic [14:0]        z_on_level;
        logic [14:0]        tilt_range;
        logic [14:0]        positive_ref;
        logic signed [15:0] negative_ref;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] avg_x;
        logic signed [SAMPLE_W-1:0] avg_y;
        logic signed [SAMPLE_W-1:0] avg_z;
        logic                       event_valid;
        logic [1:0]                 event_code;
    } result_t;

endpackage

FILE: rtl/core/tgc_cell.sv
// One history cell of the sample window: holds one three-axis sample.
// Depends on tgc_pkg for the sample type.
module tgc_cell (
    input  logic             aclk,
    input  logic             prime,
    input  logic             shift,
    input  tgc_pkg::sample_t prime_data,
    input  tgc_pkg::sample_t shift_data,
    output tgc_pkg::sample_t data
);

    tgc_pkg::sample_t data_reg;

    always_ff @(posedge aclk) begin
        if (prime) begin
            data_reg <= prime_data;
        end else if (shift) begin
            data_reg <= shift_data;
        end
    end

    assign data = data_reg;

endmodule

FILE: rtl/core/tgc_window.sv
// Sample window: a chain of history cells and the per-axis running sums.
// Depends on tgc_pkg and tgc_cell.
module tgc_window (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  tgc_pkg::sample_t sample,
    output tgc_pkg::sum_t    sum
);

    localparam int EXT_W = tgc_pkg::SUM_W - tgc_pkg::SAMPLE_W;

    tgc_pkg::sample_t cell_q [tgc_pkg::WINDOW];
    tgc_pkg::sample_t oldest;
    tgc_pkg::sum_t    sum_reg;
    tgc_pkg::sum_t    sum_next;
    logic             primed_reg;
    logic             primed_next;
    logic             prime;
    logic             shift;

    assign prime  = load && !primed_reg;
    assign shift  = load && primed_reg;
    assign oldest = cell_q[tgc_pkg::WINDOW-1];

    // The newest sample enters the first cell; the last cell holds the one
    // from a full window back, which leaves the running sum on this transfer.
    for (genvar i = 0; i < tgc_pkg::WINDOW; i++) begin : g_cell
        if (i == 0) begin : g_head
            tgc_cell u_cell (
                .aclk       (aclk),
                .prime      (prime),
                .shift      (shift),
                .prime_data (sample),
                .shift_data (sample),
                .data       (cell_q[i])
            );
        end else begin : g_body
            tgc_cell u_cell (
                .aclk       (aclk),
                .prime      (prime),
                .shift      (shift),
                .prime_data (sample),
                .shift_data (cell_q[i-1]),
                .data       (cell_q[i])
            );
        end
    end

    always_comb begin
        sum_next    = sum_reg;
        primed_next = primed_reg;
        if (prime) begin
            sum_next.x  = {sample.x, {tgc_pkg::WIN_SHIFT{1'b0}}};
            sum_next.y  = {sample.y, {tgc_pkg::WIN_SHIFT{1'b0}}};
            sum_next.z  = {sample.z, {tgc_pkg::WIN_SHIFT{1'b0}}};
            primed_next = 1'b1;
        end else if (shift) begin
            sum_next.x = sum_reg.x - {{EXT_W{oldest.x[tgc_pkg::SAMPLE_W-1]}}, oldest.x}
                                   + {{EXT_W{sample.x[tgc_pkg::SAMPLE_W-1]}}, sample.x};
            sum_next.y = sum_reg.y - {{EXT_W{oldest.y[tgc_pkg::SAMPLE_W-1]}}, oldest.y}
                                   + {{EXT_W{sample.y[tgc_pkg::SAMPLE_W-1]}}, sample.y};
            sum_next.z = sum_reg.z - {{EXT_W{oldest.z[tgc_pkg::SAMPLE_W-1]}}, oldest.z}
                                   + {{EXT_W{sample.z[tgc_pkg::SAMPLE_W-1]}}, sample.z};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg <= 1'b0;
            sum_reg    <= '0;
        end else begin
            primed_reg <= primed_next;
            sum_reg    <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

FILE: rtl/core/tgc_classifier.sv
// Tilt mode classifier with hysteresis and the registered result stage.
// Depends on tgc_pkg for the sum, configuration and result types.
module tgc_classifier (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  tgc_pkg::sum_t     sum,
    input  tgc_pkg::cfg_t     cfg,
    output tgc_pkg::result_t  result
);

    typedef enum logic [1:0] {
        MODE_RIGHT   = 2'd0,
        MODE_LEFT    = 2'd1,
        MODE_BATTERY = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    localparam int HI = tgc_pkg::SUM_W - 1;
    localparam int LO = tgc_pkg::WIN_SHIFT;

    mode_t            mode_reg;
    mode_t            mode_next;
    logic             hyst_reg;
    logic             hyst_next;
    tgc_pkg::result_t result_reg;
    tgc_pkg::result_t result_next;

    logic signed [15:0] avg_x;
    logic signed [15:0] avg_y;
    logic signed [15:0] avg_z;
    logic signed [17:0] ax;
    logic signed [17:0] ay;
    logic signed [17:0] az;
    logic signed [17:0] pos_lim;
    logic signed [17:0] neg_lim;
    logic signed [17:0] z_lim;
    logic               fired;

    // Dropping the low bits of the exact sum gives the floor average.
    assign avg_x = sum.x[HI:LO];
    assign avg_y = sum.y[HI:LO];
    assign avg_z = sum.z[HI:LO];
    assign ax    = {{2{avg_x[15]}}, avg_x};
    assign ay    = {{2{avg_y[15]}}, avg_y};
    assign az    = {{2{avg_z[15]}}, avg_z};

    always_comb begin
        pos_lim = $signed({3'b000, cfg.positive_ref}) - $signed({3'b000, cfg.tilt_range});
        neg_lim = $signed({{2{cfg.negative_ref[15]}}, cfg.negative_ref})
                + $signed({3'b000, cfg.tilt_range});
        z_lim   = $signed({3'b000, cfg.z_on_level})
                + (hyst_reg ? $signed({3'b000, cfg.hysteresis}) : 18'sd0);

        mode_next = mode_reg;
        hyst_next = hyst_reg;
        fired     = 1'b0;
        // The three tilt rules run in order, each seeing the mode the one
        // before it left.
        if (az > -z_lim) begin
            if (ax > pos_lim && ay <= pos_lim && ay >= neg_lim && mode_next != MODE_RIGHT) begin
                mode_next = MODE_RIGHT;
                hyst_next = 1'b1;
                fired     = 1'b1;
            end
            if (ay > pos_lim && ax <= pos_lim && ax >= neg_lim && mode_next != MODE_LEFT) begin
                mode_next = MODE_LEFT;
                hyst_next = 1'b1;
                fired     = 1'b1;
            end
            if (ay < neg_lim && ax <= pos_lim && ax >= neg_lim
                && mode_next != MODE_BATTERY) begin
                mode_next = MODE_BATTERY;
                hyst_next = 1'b1;
                fired     = 1'b1;
            end
        end else if (mode_next != MODE_NONE) begin
            mode_next = MODE_NONE;
            hyst_next = 1'b0;
            fired     = 1'b1;
        end

        result_next.avg_x       = avg_x;
        result_next.avg_y       = avg_y;
        result_next.avg_z       = avg_z;
        result_next.event_valid = fired;
        result_next.event_code  = fired ? mode_next : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_BATTERY;
            hyst_reg <= 1'b0;
        end else if (take) begin
            mode_reg <= mode_next;
            hyst_reg <= hyst_next;
        end
        if (take) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

FILE: rtl/core/tilt_gesture_classifier.sv
// Top level of the tilt gesture classifier: handshake, configuration
// registers, sample window and classifier. Depends on tgc_pkg, tgc_window,
// tgc_classifier and the assertion header.
//
// Usage:
// - Input channel s_*: one three-axis accelerometer sample per transfer.
// - Result channel m_*: one result per accepted sample, in order: the three
//   32-sample moving averages and, when the tilt mode changed, an event with
//   the new mode (0 right, 1 left, 2 battery, 3 none).
// - Configuration: cfg_we writes cfg_wdata into register cfg_addr; write only
//   while no sample is in flight.
// - Result path: the window sums load at the edge that accepts a sample, and
//   the classifier registers the result at the next edge on which the result
//   register is free; m_valid rises with it.
// - Throughput: one sample per cycle while m_ready is high, set by the registered
//   sum update in the window and the registered mode update in the classifier.
// - Reset: registers return to their defaults, the window is unprimed (the
//   first sample fills every cell) and the mode is battery.
// - Stall: while m_ready is low the result holds; one more sample can sit in
//   the window stage, after which s_ready drops until the result moves.
`include "tilt_gesture_classifier_assert.svh"

module tilt_gesture_classifier (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_sample_x,
    input  logic signed [15:0] s_sample_y,
    input  logic signed [15:0] s_sample_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_avg_x,
    output logic signed [15:0] m_avg_y,
    output logic signed [15:0] m_avg_z,
    output logic               m_event_valid,
    output logic [1:0]         m_event_code
);

    tgc_pkg::cfg_t    cfg_reg;
    tgc_pkg::cfg_t    cfg_next;
    logic             stage_valid_reg;
    logic             stage_valid_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic             out_free;
    logic             accept;
    logic             advance;
    tgc_pkg::sample_t sample;
    tgc_pkg::sum_t    sum;
    tgc_pkg::result_t result;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !stage_valid_reg || out_free;
    assign accept   = s_valid && s_ready;
    assign advance  = stage_valid_reg && out_free;

    always_comb begin
        stage_valid_next = stage_valid_reg;
        if (accept) begin
            stage_valid_next = 1'b1;
        end else if (advance) begin
            stage_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                tgc_pkg::CFG_HYSTERESIS:   cfg_next.hysteresis   = cfg_wdata[14:0];
                tgc_pkg::CFG_Z_ON_LEVEL:   cfg_next.z_on_level   = cfg_wdata[14:0];
                tgc_pkg::CFG_TILT_RANGE:   cfg_next.tilt_range   = cfg_wdata[14:0];
                tgc_pkg::CFG_POSITIVE_REF: cfg_next.positive_ref = cfg_wdata[14:0];
                tgc_pkg::CFG_NEGATIVE_REF: cfg_next.negative_ref = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg      <= 1'b0;
            m_valid_reg          <= 1'b0;
            cfg_reg.hysteresis   <= tgc_pkg::RST_HYSTERESIS;
            cfg_reg.z_on_level   <= tgc_pkg::RST_Z_ON_LEVEL;
            cfg_reg.tilt_range   <= tgc_pkg::RST_TILT_RANGE;
            cfg_reg.positive_ref <= tgc_pkg::RST_POSITIVE_REF;
            cfg_reg.negative_ref <= tgc_pkg::RST_NEGATIVE_REF;
        end else begin
            stage_valid_reg <= stage_valid_next;
            m_valid_reg     <= m_valid_next;
            cfg_reg         <= cfg_next;
        end
    end

    assign sample.x = s_sample_x;
    assign sample.y = s_sample_y;
    assign sample.z = s_sample_z;

    tgc_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (accept),
        .sample  (sample),
        .sum     (sum)
    );

    tgc_classifier u_classifier (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (advance),
        .sum     (sum),
        .cfg     (cfg_reg),
        .result  (result)
    );

    assign m_valid       = m_valid_reg;
    assign m_avg_x       = result.avg_x;
    assign m_avg_y       = result.avg_y;
    assign m_avg_z       = result.avg_z;
    assign m_event_valid = result.event_valid;
    assign m_event_code  = result.event_code;

    // An empty window stage always takes a sample.
    `TGC_ASSERT_IMP(a_ready_when_empty, aclk, aresetn, !stage_valid_reg, s_ready)
    // Back-pressure reaches the input once both stages are occupied and m_ready is low.
    `TGC_ASSERT_IMP(a_full_stalls_input, aclk, aresetn,
        stage_valid_reg && m_valid_reg && !m_ready, !s_ready)
    // A sample in the window stage reaches the result register when it is free.
    `TGC_ASSERT_NXT(a_advance_fills_output, aclk, aresetn, advance, m_valid)
    // An event code is only reported together with an event.
    `TGC_ASSERT_IMP(a_code_needs_event, aclk, aresetn,
        m_valid && !m_event_valid, m_event_code == 2'd0)

endmodule

FILE: tb/sv/tb_tilt_gesture_classifier.sv
// Self-checking testbench for tilt_gesture_classifier: posture sequences, raw noise and
// register settings are sent through the block and every result is checked field by field.
// Depends on tgc_pkg and the classifier RTL; an in-line predictor supplies expected results.
module tb_tilt_gesture_classifier;

    localparam int SAMPLE_MAX    = 2 ** (tgc_pkg::SAMPLE_W - 1) - 1;
    localparam int SAMPLE_MIN    = -(2 ** (tgc_pkg::SAMPLE_W - 1));
    localparam int IDLE_PCT      = 20;
    localparam int HOLD_CYCLES   = 64;
    localparam int SETTLE_CYCLES = 4;
    localparam int IDLE_LIMIT    = 2000;
    localparam int MAX_REPORTS   = 30;

    localparam logic [2:0] CFG_UNUSED_FIRST = tgc_pkg::CFG_NEGATIVE_REF + 3'd1;
    localparam logic [2:0] CFG_UNUSED_LAST  = 3'd7;

    typedef enum logic [1:0] {
        MODE_RIGHT   = 2'd0,
        MODE_LEFT    = 2'd1,
        MODE_BATTERY = 2'd2,
        MODE_NONE    = 2'd3
    } tilt_mode_e;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               cfg_we        = 1'b0;
    logic [2:0]         cfg_addr      = '0;
    logic [15:0]        cfg_wdata     = '0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_sample_x    = '0;
    logic signed [15:0] s_sample_y    = '0;
    logic signed [15:0] s_sample_z    = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic signed [15:0] m_avg_x;
    logic signed [15:0] m_avg_y;
    logic signed [15:0] m_avg_z;
    logic               m_event_valid;
    logic [1:0]         m_event_code;

    // Predictor state: window of past samples, running sums, classifier mode.
    int                 ring [3][tgc_pkg::WINDOW];
    int                 run_sum [3];
    int                 slot;
    bit                 window_full;
    tilt_mode_e         mode;
    bit                 hyst_on;
    logic [14:0]        hyst_val;
    logic [14:0]        z_on_val;
    logic [14:0]        tilt_val;
    logic [14:0]        pos_ref_val;
    logic signed [15:0] neg_ref_val;

    tgc_pkg::result_t   pending_reports [$];

    int  errors = 0;
    int  samples_sent = 0;
    int  settings_loaded = 0;
    int  mode_events [4] = '{0, 0, 0, 0};
    bit  steady = 1'b0;
    int  hold_req = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  quiet_cycles = 0;

    tilt_gesture_classifier DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_x    (s_sample_x),
        .s_sample_y    (s_sample_y),
        .s_sample_z    (s_sample_z),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_avg_x       (m_avg_x),
        .m_avg_y       (m_avg_y),
        .m_avg_z       (m_avg_z),
        .m_event_valid (m_event_valid),
        .m_event_code  (m_event_code)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void apply_register(input logic [2:0] addr, input logic [15:0] data);
        case (addr)
            tgc_pkg::CFG_HYSTERESIS:   hyst_val    = data[14:0];
            tgc_pkg::CFG_Z_ON_LEVEL:   z_on_val    = data[14:0];
            tgc_pkg::CFG_TILT_RANGE:   tilt_val    = data[14:0];
            tgc_pkg::CFG_POSITIVE_REF: pos_ref_val = data[14:0];
            tgc_pkg::CFG_NEGATIVE_REF: neg_ref_val = data;
            default: ;
        endcase
    endfunction

    // Advances the window by one sample and runs the tilt rules on the new averages.
    function automatic tgc_pkg::result_t average_and_classify(
        input logic signed [15:0] sx, input logic signed [15:0] sy,
        input logic signed [15:0] sz);
        tgc_pkg::result_t rep;
        int smp [3];
        int avg [3];
        int p_lim;
        int n_lim;
        int z_lim;
        bit fired;
        smp[0] = int'(sx);
        smp[1] = int'(sy);
        smp[2] = int'(sz);
        fired = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (!window_full) begin
                for (int i = 0; i < tgc_pkg::WINDOW; i++) ring[a][i] = smp[a];
                run_sum[a] = smp[a] * tgc_pkg::WINDOW;
            end else begin
                run_sum[a] = run_sum[a] - ring[a][slot] + smp[a];
                ring[a][slot] = smp[a];
            end
            avg[a] = run_sum[a] >>> tgc_pkg::WIN_SHIFT;
        end
        slot = window_full ? (slot + 1) % tgc_pkg::WINDOW : 0;
        window_full = 1'b1;

        p_lim = int'(pos_ref_val) - int'(tilt_val);
        n_lim = int'(neg_ref_val) + int'(tilt_val);
        z_lim = int'(z_on_val) + (hyst_on ? int'(hyst_val) : 0);

        // The three tilt rules run in sequence, each seeing the mode left by the previous one.
        if (avg[2] > -z_lim) begin
            if (avg[0] > p_lim && avg[1] <= p_lim && avg[1] >= n_lim && mode != MODE_RIGHT) begin
                mode = MODE_RIGHT;
                hyst_on = 1'b1;
                fired = 1'b1;
            end
            if (avg[1] > p_lim && avg[0] <= p_lim && avg[0] >= n_lim && mode != MODE_LEFT) begin
                mode = MODE_LEFT;
                hyst_on = 1'b1;
                fired = 1'b1;
            end
            if (avg[1] < n_lim && avg[0] <= p_lim && avg[0] >= n_lim
                    && mode != MODE_BATTERY) begin
                mode = MODE_BATTERY;
                hyst_on = 1'b1;
                fired = 1'b1;
            end
        end else if (mode != MODE_NONE) begin
            mode = MODE_NONE;
            hyst_on = 1'b0;
            fired = 1'b1;
        end

        rep.avg_x       = 16'(avg[0]);
        rep.avg_y       = 16'(avg[1]);
        rep.avg_z       = 16'(avg[2]);
        rep.event_valid = fired;
        rep.event_code  = fired ? mode : '0;
        return rep;
    endfunction

    function automatic logic signed [15:0] jitter(input int center, input int spread);
        int v;
        v = center + int'($urandom_range(2 * spread)) - spread;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        else if (v < SAMPLE_MIN) v = SAMPLE_MIN;
        return 16'(v);
    endfunction

    task automatic check_field(input string fname, input logic signed [16:0] want,
                               input logic signed [16:0] got);
        if (got !== want) begin
            if (errors < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            errors++;
        end
    endtask

    // Result side: random stalls unless steady, and a long hold-off when the stimulus asks.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        tgc_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: result transfer with nothing expected, actual avg %0d %0d %0d",
                             $time, m_avg_x, m_avg_y, m_avg_z);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                check_field("avg_x", want.avg_x, m_avg_x);
                check_field("avg_y", want.avg_y, m_avg_y);
                check_field("avg_z", want.avg_z, m_avg_z);
                check_field("event_valid", want.event_valid, m_event_valid);
                check_field("event_code", want.event_code, m_event_code);
                if (want.event_valid) mode_events[want.event_code]++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Valid stays high from one transfer to the next unless a random gap is taken first.
    task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                               input logic signed [15:0] z);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_sample_x <= x;
        s_sample_y <= y;
        s_sample_z <= z;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_reports.push_back(average_and_classify(x, y, z));
        samples_sent++;
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes all five registers (bit 15 of the 15-bit ones at random) and one unused index.
    task automatic load_config(input logic [14:0] hyst, input logic [14:0] z_on,
                               input logic [14:0] t_range, input logic [14:0] p_ref,
                               input logic signed [15:0] n_ref);
        logic [2:0]  addr [6];
        logic [15:0] data [6];
        wait_drain();
        addr[0] = tgc_pkg::CFG_HYSTERESIS;   data[0] = {1'($urandom_range(1)), hyst};
        addr[1] = tgc_pkg::CFG_Z_ON_LEVEL;   data[1] = {1'($urandom_range(1)), z_on};
        addr[2] = tgc_pkg::CFG_TILT_RANGE;   data[2] = {1'($urandom_range(1)), t_range};
        addr[3] = tgc_pkg::CFG_POSITIVE_REF; data[3] = {1'($urandom_range(1)), p_ref};
        addr[4] = tgc_pkg::CFG_NEGATIVE_REF; data[4] = n_ref;
        addr[5] = 3'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_LAST));
        data[5] = 16'($urandom);
        for (int i = 0; i < 6; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= addr[i];
            cfg_wdata <= data[i];
            @(posedge aclk);
            apply_register(addr[i], data[i]);
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
        settings_loaded++;
    endtask

    // Runs of a held posture with jitter; short runs and raw noise break the sequences up.
    task automatic run_postures(input int n_items);
        int sent;
        int pick;
        int run_len;
        int mag;
        int spread;
        sent = 0;
        while (sent < n_items) begin
            pick    = $urandom_range(99);
            run_len = $urandom_range(1, 60);
            mag     = $urandom_range(9000, SAMPLE_MAX);
            spread  = $urandom_range(0, 4000);
            if (pick >= 88) run_len = $urandom_range(1, 8);
            for (int i = 0; i < run_len && sent < n_items; i++) begin
                if (pick < 20)
                    send_sample(jitter(mag, spread), jitter(0, spread), jitter(0, spread));
                else if (pick < 40)
                    send_sample(jitter(0, spread), jitter(mag, spread), jitter(0, spread));
                else if (pick < 60)
                    send_sample(jitter(0, spread), jitter(-mag, spread), jitter(0, spread));
                else if (pick < 75)
                    send_sample(jitter(0, spread), jitter(0, spread), jitter(-mag, spread));
                else if (pick < 88)
                    send_sample(jitter(0, spread), jitter(0, spread), jitter(mag, spread));
                else
                    send_sample(16'($urandom), 16'($urandom), 16'($urandom));
                sent++;
            end
        end
    endtask

    task automatic test_priming_and_extremes();
        // The first sample fills the whole window, so its average is the sample itself.
        send_sample(16384, 0, 100);
        send_sample(16'(SAMPLE_MAX), 16'(SAMPLE_MAX), 16'(SAMPLE_MAX));
        send_sample(16'(SAMPLE_MIN), 16'(SAMPLE_MIN), 16'(SAMPLE_MIN));
        send_sample(16'(SAMPLE_MAX), 16'(SAMPLE_MIN), 0);
        send_sample(16'(SAMPLE_MIN), 16'(SAMPLE_MAX), -1);
        send_sample(-1, -1, -1);
        send_sample(0, 0, 0);
        repeat (3) send_sample(0, 0, 16'(SAMPLE_MIN));
    endtask

    task automatic test_overlapping_thresholds();
        // The tilt band is inverted here, so only the face-down rule can fire.
        load_config(15'd0, 15'd0, 15'h7FFF, 15'd0, 16'sd0);
        repeat (4) send_sample(0, 0, 16'(SAMPLE_MIN));
        repeat (4) send_sample(16'(SAMPLE_MAX), 16'(SAMPLE_MIN), 16'(SAMPLE_MAX));
    endtask

    task automatic test_default_thresholds();
        load_config(tgc_pkg::RST_HYSTERESIS, tgc_pkg::RST_Z_ON_LEVEL, tgc_pkg::RST_TILT_RANGE,
                    tgc_pkg::RST_POSITIVE_REF, tgc_pkg::RST_NEGATIVE_REF);
        steady <= 1'b1;
        run_postures(240);
        steady <= 1'b0;
        run_postures(100);
    endtask

    task automatic test_random_thresholds();
        repeat (3) begin
            load_config(15'($urandom_range(0, 8000)), 15'($urandom_range(2000, 12000)),
                        15'($urandom_range(0, 8000)), 15'($urandom_range(8000, SAMPLE_MAX)),
                        16'(-int'($urandom_range(8000, -SAMPLE_MIN))));
            run_postures(120);
        end
    endtask

    task automatic test_threshold_extremes();
        load_config(15'd0, 15'd0, 15'd0, 15'd0, 16'sd0);
        run_postures(150);
        load_config(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 16'(SAMPLE_MIN));
        run_postures(150);
    endtask

    task automatic test_output_stall();
        load_config(tgc_pkg::RST_HYSTERESIS, tgc_pkg::RST_Z_ON_LEVEL, tgc_pkg::RST_TILT_RANGE,
                    tgc_pkg::RST_POSITIVE_REF, tgc_pkg::RST_NEGATIVE_REF);
        steady <= 1'b1;
        hold_req <= hold_req + 1;
        run_postures(40);
        steady <= 1'b0;
        // Sender stops until every outstanding result has been taken.
        wait_drain();
        run_postures(30);
    endtask

    task automatic test_raw_noise();
        load_config(15'($urandom), 15'($urandom), 15'($urandom), 15'($urandom),
                    16'($urandom) | 16'h8000);
        repeat (200) send_sample(16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial begin
        int drain_wait;
        ring        = '{default: '{default: 0}};
        run_sum     = '{0, 0, 0};
        slot        = 0;
        window_full = 1'b0;
        mode        = MODE_BATTERY;
        hyst_on     = 1'b0;
        hyst_val    = tgc_pkg::RST_HYSTERESIS;
        z_on_val    = tgc_pkg::RST_Z_ON_LEVEL;
        tilt_val    = tgc_pkg::RST_TILT_RANGE;
        pos_ref_val = tgc_pkg::RST_POSITIVE_REF;
        neg_ref_val = tgc_pkg::RST_NEGATIVE_REF;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_priming_and_extremes();
        test_overlapping_thresholds();
        test_default_thresholds();
        test_random_thresholds();
        test_threshold_extremes();
        test_output_stall();
        test_raw_noise();

        s_valid <= 1'b0;
        drain_wait = 0;
        while (pending_reports.size() != 0 && drain_wait < IDLE_LIMIT) begin
            @(posedge aclk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_reports.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_reports.size());
            errors++;
        end

        $display("Covered %0d samples under %0d register settings, with output hold-off.",
                 samples_sent, settings_loaded);
        $display("Mode changes seen: right %0d, left %0d, battery %0d, none %0d.",
                 mode_events[MODE_RIGHT], mode_events[MODE_LEFT],
                 mode_events[MODE_BATTERY], mode_events[MODE_NONE]);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
